### hw/rtl/calendar_millisecond_converter_assert.svh
// Assertion macros for the calendar converter checker.
`ifndef CALENDAR_MILLISECOND_CONVERTER_ASSERT_SVH
`define CALENDAR_MILLISECOND_CONVERTER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define CMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CMC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/cmc_pkg.sv
`default_nettype none
package cmc_pkg;

	localparam int YW   = 14;
	localparam int DAYW = 22;
	localparam int ACCW = 50;
	localparam int MSW  = 45;

	localparam logic [YW-1:0] BASE_YEAR  = 14'd1600;
	localparam logic [26:0]   MS_PER_DAY = 27'd86400000;
	localparam logic [21:0]   MS_PER_HR  = 22'd3600000;
	localparam logic [21:0]   MS_PER_MIN = 22'd60000;
	localparam logic [21:0]   MS_PER_SEC = 22'd1000;
	// floor(2^45 / ms per day), day estimate from count bits 44..13
	localparam logic [18:0]   DAY_RECIP  = 19'd407226;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_DAY   = 3'd1;
	localparam logic [2:0] ST_BAD_MONTH = 3'd2;
	localparam logic [2:0] ST_BAD_YEAR  = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	// action codes
	localparam logic [1:0] ACT_TO_COUNT = 2'd0;
	localparam logic [1:0] ACT_TO_DATE  = 2'd1;
	localparam logic [1:0] ACT_ADD      = 2'd2;
	localparam logic [1:0] ACT_SUB      = 2'd3;

	// datapath operations
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_CHECK = 4'd2;
	localparam logic [3:0] OP_YW1   = 4'd3;
	localparam logic [3:0] OP_MW1   = 4'd4;
	localparam logic [3:0] OP_MUL   = 4'd5;
	localparam logic [3:0] OP_ACT   = 4'd6;
	localparam logic [3:0] OP_RANGE = 4'd7;
	localparam logic [3:0] OP_DIV   = 4'd8;
	localparam logic [3:0] OP_YW2   = 4'd9;
	localparam logic [3:0] OP_MW2   = 4'd10;
	localparam logic [3:0] OP_TIME  = 4'd11;
	localparam logic [3:0] OP_OUT   = 4'd12;
	localparam logic [3:0] OP_ERR   = 4'd13;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millisecond;
		logic [44:0] amount_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [5:0]  out_second;
		logic [9:0]  out_millisecond;
		logic [44:0] serial_ms;
	} rsp_t;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic done;     // current multi-cycle op finishes this cycle
		logic bad;      // error status latched
		logic to_date;  // transaction skips the date-to-count half
		logic out_free; // output register can take a result
	} sts_t;

	// Gregorian leap test; divisibility by 25 via reciprocal multiply
	function automatic logic is_leap(input logic [YW-1:0] y);
		logic [26:0] p;
		logic [9:0]  q;
		logic        div25;
		p     = 27'(y) * 27'd5243;
		q     = p[26:17];
		div25 = (14'(q) * 14'd25) == y;
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	// month length, month index from zero
	function automatic logic [4:0] month_len(input logic lp, input logic [3:0] idx);
		logic [4:0] len;
		unique case (idx)
			4'd1:                      len = lp ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic longint unsigned leaps_upto(input longint unsigned x);
		return x / 4 - x / 100 + x / 400;
	endfunction

	function automatic longint unsigned days_before(input longint unsigned y);
		return 365 * (y - 1600) + leaps_upto(y - 1) - leaps_upto(1599);
	endfunction

	// count limit for a year span, capped at 2^45
	function automatic logic [45:0] count_limit(input int unsigned span);
		longint unsigned lim;
		lim = days_before(64'(1600 + span)) * 64'd86400000;
		return (lim > 64'h2000_0000_0000) ? 46'h2000_0000_0000 : 46'(lim);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/cmc_ctrl.sv
`default_nettype none
module cmc_ctrl import cmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_YW1   = 4'd2;
	localparam logic [3:0] S_MW1   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_ACT   = 4'd5;
	localparam logic [3:0] S_RANGE = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_YW2   = 4'd8;
	localparam logic [3:0] S_MW2   = 4'd9;
	localparam logic [3:0] S_TIME  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_ERR   = 4'd12;

	logic [3:0] state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.op  = OP_CHECK;
				state_d = S_YW1;
			end
			S_YW1: begin
				priority if (sts.bad) begin
					state_d = S_ERR;
				end else if (sts.to_date) begin
					state_d = S_ACT;
				end else begin
					cmd.op = OP_YW1;
					if (sts.done) state_d = S_MW1;
				end
			end
			S_MW1: begin
				cmd.op = OP_MW1;
				if (sts.done) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op = OP_MUL;
				if (sts.done) state_d = S_ACT;
			end
			S_ACT: begin
				cmd.op  = OP_ACT;
				state_d = S_RANGE;
			end
			S_RANGE: begin
				cmd.op  = OP_RANGE;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.bad) begin
					state_d = S_ERR;
				end else begin
					cmd.op = OP_DIV;
					if (sts.done) state_d = S_YW2;
				end
			end
			S_YW2: begin
				cmd.op = OP_YW2;
				if (sts.done) state_d = S_MW2;
			end
			S_MW2: begin
				cmd.op = OP_MW2;
				if (sts.done) state_d = S_TIME;
			end
			S_TIME: begin
				cmd.op = OP_TIME;
				if (sts.done) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.op  = OP_ERR;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

### hw/rtl/cmc_datapath.sv
`default_nettype none
module cmc_datapath import cmc_pkg::*; #(
	parameter int unsigned YEAR_SPAN = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam logic [45:0]   LIMIT = count_limit(YEAR_SPAN);
	localparam logic [YW-1:0] YEND  = YW'(1600 + YEAR_SPAN);

	req_t            req_q;
	logic [YW-1:0]   yr_q;
	logic [DAYW-1:0] days_q;
	logic [3:0]      mon_q;
	logic [ACCW-1:0] acc_q;
	logic [MSW-1:0]  serial_q;
	logic [26:0]     rem_q;
	logic [2:0]      err_q;
	logic [1:0]      mstep_q;
	logic [1:0]      div_cnt_q;
	logic [1:0]      tidx_q;
	logic [4:0]      hr_q;
	logic [5:0]      mi_q;
	logic [5:0]      se_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	// date check
	logic [YW-1:0] year_in;
	logic          lp_in;
	logic [4:0]    mlen_in;
	logic [2:0]    chk_code;

	assign year_in = YW'(req_q.year);
	assign lp_in   = is_leap(year_in);
	assign mlen_in = month_len(lp_in, req_q.month - 4'd1);

	always_comb begin
		priority if (req_q.day == 5'd0)                            chk_code = ST_BAD_DAY;
		else if (req_q.month == 4'd0 || req_q.month > 4'd12)       chk_code = ST_BAD_MONTH;
		else if (req_q.day > mlen_in)                              chk_code = ST_BAD_DAY;
		else if (year_in < BASE_YEAR || year_in >= YEND)           chk_code = ST_BAD_YEAR;
		else                                                       chk_code = ST_OK;
	end

	// calendar walk helpers
	logic          lp_yr;
	logic [8:0]    ylen;
	logic [4:0]    mlen;
	logic          yw1_more, mw1_more, yw2_more, mw2_more;

	assign lp_yr    = is_leap(yr_q);
	assign ylen     = lp_yr ? 9'd366 : 9'd365;
	assign mlen     = month_len(lp_yr, mon_q);
	assign yw1_more = (yr_q != year_in);
	assign mw1_more = (5'(mon_q) + 5'd1) < 5'(req_q.month);
	assign yw2_more = (days_q >= DAYW'(ylen)) && (yr_q < YEND);
	assign mw2_more = (mon_q < 4'd11) && (days_q >= DAYW'(mlen));

	// shared multiplier for the count build-up and the day split
	logic [1:0]  msel;
	logic [21:0] mul_a;
	logic [26:0] mul_b;
	logic [48:0] prod;

	assign msel = (cmd.op == OP_DIV) ? 2'd0 : mstep_q;

	always_comb begin
		unique case (msel)
			2'd0: begin mul_a = days_q;              mul_b = MS_PER_DAY;       end
			2'd1: begin mul_a = 22'(req_q.hour);     mul_b = 27'(MS_PER_HR);   end
			2'd2: begin mul_a = 22'(req_q.minute);   mul_b = 27'(MS_PER_MIN);  end
			default: begin mul_a = 22'(req_q.second); mul_b = 27'(MS_PER_SEC); end
		endcase
	end
	assign prod = 49'(mul_a) * 49'(mul_b);

	// action and range
	logic [ACCW-1:0] amt_ext;
	logic            ge_lim, lt_amt;

	assign amt_ext = ACCW'(req_q.amount_ms);
	assign ge_lim  = acc_q >= ACCW'(LIMIT);
	assign lt_amt  = acc_q < amt_ext;

	// day split: reciprocal estimate (low by at most two), then compare and subtract
	logic [50:0] est_prod;
	logic [18:0] day_est;
	logic        day_ge;

	assign est_prod = 51'(acc_q[44:13]) * 51'(DAY_RECIP);
	assign day_est  = est_prod[50:32];
	assign day_ge   = acc_q >= ACCW'(MS_PER_DAY);

	// time of day split
	logic [21:0] tconst;
	logic        t_ge;

	always_comb begin
		unique case (tidx_q)
			2'd0:    tconst = MS_PER_HR;
			2'd1:    tconst = MS_PER_MIN;
			default: tconst = MS_PER_SEC;
		endcase
	end
	assign t_ge = rem_q >= 27'(tconst);

	logic done_c;

	always_comb begin
		unique case (cmd.op)
			OP_YW1:  done_c = !yw1_more;
			OP_MW1:  done_c = !mw1_more;
			OP_MUL:  done_c = (mstep_q == 2'd3);
			OP_DIV:  done_c = (div_cnt_q == 2'd2) && !day_ge;
			OP_YW2:  done_c = !yw2_more;
			OP_MW2:  done_c = !mw2_more;
			OP_TIME: done_c = (tidx_q == 2'd2) && !t_ge;
			default: done_c = 1'b0;
		endcase
	end
	assign sts.done     = done_c;
	assign sts.bad      = (err_q != ST_OK);
	assign sts.to_date  = (req_q.action == ACT_TO_DATE);
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				req_q <= req;
				acc_q <= ACCW'(req.amount_ms);
				err_q <= ST_OK;
			end
			OP_CHECK: begin
				if (req_q.action != ACT_TO_DATE) begin
					err_q   <= chk_code;
					yr_q    <= BASE_YEAR;
					days_q  <= '0;
					mon_q   <= '0;
					mstep_q <= '0;
					acc_q   <= ACCW'(req_q.millisecond);
				end
			end
			OP_YW1: begin
				if (yw1_more) begin
					days_q <= days_q + DAYW'(ylen);
					yr_q   <= yr_q + YW'(1);
				end
			end
			OP_MW1: begin
				if (mw1_more) begin
					days_q <= days_q + DAYW'(mlen);
					mon_q  <= mon_q + 4'd1;
				end else begin
					days_q <= days_q + DAYW'(req_q.day) - DAYW'(1);
				end
			end
			OP_MUL: begin
				acc_q   <= acc_q + ACCW'(prod);
				mstep_q <= mstep_q + 2'd1;
			end
			OP_ACT: begin
				if (ge_lim || (req_q.action == ACT_SUB && lt_amt)) err_q <= ST_RANGE;
				if (req_q.action == ACT_ADD) acc_q <= acc_q + amt_ext;
				else if (req_q.action == ACT_SUB && !lt_amt) acc_q <= acc_q - amt_ext;
			end
			OP_RANGE: begin
				if (ge_lim) err_q <= ST_RANGE;
				serial_q  <= acc_q[MSW-1:0];
				div_cnt_q <= '0;
				rem_q     <= '0;
			end
			OP_DIV: begin
				yr_q   <= BASE_YEAR;
				mon_q  <= '0;
				tidx_q <= '0;
				hr_q   <= '0;
				mi_q   <= '0;
				se_q   <= '0;
				priority if (div_cnt_q == 2'd0) begin
					days_q    <= DAYW'(day_est);
					div_cnt_q <= 2'd1;
				end else if (div_cnt_q == 2'd1) begin
					acc_q     <= acc_q - ACCW'(prod);
					div_cnt_q <= 2'd2;
				end else if (day_ge) begin
					acc_q  <= acc_q - ACCW'(MS_PER_DAY);
					days_q <= days_q + DAYW'(1);
				end else begin
					rem_q <= acc_q[26:0];
				end
			end
			OP_YW2: begin
				if (yw2_more) begin
					days_q <= days_q - DAYW'(ylen);
					yr_q   <= yr_q + YW'(1);
				end
			end
			OP_MW2: begin
				if (mw2_more) begin
					days_q <= days_q - DAYW'(mlen);
					mon_q  <= mon_q + 4'd1;
				end
			end
			OP_TIME: begin
				if (t_ge) begin
					rem_q <= rem_q - 27'(tconst);
					unique case (tidx_q)
						2'd0:    hr_q <= hr_q + 5'd1;
						2'd1:    mi_q <= mi_q + 6'd1;
						default: se_q <= se_q + 6'd1;
					endcase
				end else if (tidx_q != 2'd2) begin
					tidx_q <= tidx_q + 2'd1;
				end
			end
			OP_OUT: begin
				rsp_q.status          <= ST_OK;
				rsp_q.out_year        <= yr_q[11:0];
				rsp_q.out_month       <= mon_q + 4'd1;
				rsp_q.out_day         <= days_q[4:0] + 5'd1;
				rsp_q.out_hour        <= hr_q;
				rsp_q.out_minute      <= mi_q;
				rsp_q.out_second      <= se_q;
				rsp_q.out_millisecond <= rem_q[9:0];
				rsp_q.serial_ms       <= serial_q;
			end
			OP_ERR: begin
				rsp_q <= '{status: err_q, default: '0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT || cmd.op == OP_ERR) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

### hw/rtl/calendar_millisecond_converter.sv
// Gregorian date / millisecond-count converter.
// req channel: one transaction names an action (date to count, count to
// date, add offset, subtract offset) with a date, a time and amount_ms.
// rsp channel: one transaction per request with a status and the result
// date, time and serial count (all zero but status on an error).
// One request is worked at a time; req_stall is high from the accept until
// the result has been handed to the output register.
// Run time grows with the years past 1600 walked in each of the two year
// walks, with the months walked on each side and with the hour, minute
// and second of the result; the two year walks dominate.
// A new request is taken while the previous result still waits in the
// output register; a stalled result holds and the next finished result
// waits in the controller until the register frees.
// Reset clears the controller and the output valid; no clearing pass.
`default_nettype none
module calendar_millisecond_converter import cmc_pkg::*; #(
	parameter int unsigned YEAR_SPAN = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: one state per step of the conversion
	cmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// walks, shared multiplier, reciprocal day split, output register
	cmc_datapath #(
		.YEAR_SPAN (YEAR_SPAN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

### hw/rtl/cmc_checker.sv
`default_nettype none
`include "calendar_millisecond_converter_assert.svh"
module cmc_checker import cmc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// one transaction in flight: an accept closes the input side
	`CMC_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "accept not followed by stall")
	`CMC_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)), "stalled result changed")
	`CMC_ASSERT(a_err_zero, (rsp_valid && rsp.status != ST_OK) |-> (rsp.serial_ms == '0 && rsp.out_year == '0 && rsp.out_month == '0), "error result not cleared")
	`CMC_ASSERT(a_ok_month, (rsp_valid && rsp.status == ST_OK) |-> (rsp.out_month >= 4'd1 && rsp.out_month <= 4'd12), "month out of range")
	`CMC_ASSERT_ALWAYS(a_status_code, rsp_valid |-> (rsp.status <= ST_RANGE), "bad status code")

endmodule

bind calendar_millisecond_converter cmc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire

### sim/calendar_millisecond_converter_test.sv
`timescale 1ns / 100ps
`default_nettype none
module calendar_millisecond_converter_test;
	import cmc_pkg::*;

	localparam int unsigned SPAN = 1024;
	localparam longint unsigned DAY_MS = 64'd86400000;
	// idle cycles with no transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 540;

	// Predicted response queue plus the compare logic.
	class conversion_scoreboard;
		rsp_t pending[$];
		int mismatches;
		int stray;

		function bit leap(longint unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		function longint unsigned leap_count(longint unsigned x);
			return x / 4 - x / 100 + x / 400;
		endfunction

		function longint unsigned year_start_day(longint unsigned y);
			return 365 * (y - 1600) + leap_count(y - 1) - leap_count(1599);
		endfunction

		function longint unsigned mdays(bit lp, int m0);
			int tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			return (m0 == 1 && lp) ? 29 : tab[m0];
		endfunction

		function longint unsigned serial_cap();
			longint unsigned lim;
			lim = year_start_day(1600 + SPAN) * DAY_MS;
			return (lim > 64'h2000_0000_0000) ? 64'h2000_0000_0000 : lim;
		endfunction

		// Computes the response a request must produce.
		function rsp_t convert(req_t r);
			rsp_t o;
			longint unsigned cnt, days, rem, y, len;
			bit lp;
			logic [2:0] st;
			int m;
			o = '0;
			st = ST_OK;
			cnt = 0;
			if (r.action == ACT_TO_DATE) begin
				cnt = r.amount_ms;
				if (cnt >= serial_cap()) st = ST_RANGE;
			end else begin
				lp = leap(r.year);
				if (r.day == 0) st = ST_BAD_DAY;
				else if (r.month == 0 || r.month > 12) st = ST_BAD_MONTH;
				else if (r.day > mdays(lp, r.month - 1)) st = ST_BAD_DAY;
				else if (r.year < 1600 || r.year >= 1600 + SPAN) st = ST_BAD_YEAR;
				else begin
					days = year_start_day(r.year);
					for (int i = 0; i + 1 < r.month; i++) days += mdays(lp, i);
					days += r.day - 1;
					cnt = days * DAY_MS + r.millisecond + r.second * 1000
						+ r.minute * 60000 + r.hour * 3600000;
					if (cnt >= serial_cap()) st = ST_RANGE;
				end
				if (st == ST_OK && r.action == ACT_ADD) begin
					cnt += r.amount_ms;
					if (cnt >= serial_cap()) st = ST_RANGE;
				end else if (st == ST_OK && r.action == ACT_SUB) begin
					if (cnt < r.amount_ms) st = ST_RANGE;
					else cnt -= r.amount_ms;
				end
			end
			if (st != ST_OK) begin
				o.status = st;
				return o;
			end
			days = cnt / DAY_MS;
			rem = cnt % DAY_MS;
			y = 1600;
			for (int k = 0; k < SPAN; k++) begin
				len = leap(y) ? 366 : 365;
				if (days < len) break;
				days -= len;
				y++;
			end
			lp = leap(y);
			for (m = 0; m < 11 && days >= mdays(lp, m); m++) days -= mdays(lp, m);
			o.status = ST_OK;
			o.out_year = y[11:0];
			o.out_month = 4'(m + 1);
			o.out_day = 5'(days + 1);
			o.out_hour = 5'(rem / 3600000);
			o.out_minute = 6'((rem / 60000) % 60);
			o.out_second = 6'((rem / 1000) % 60);
			o.out_millisecond = 10'(rem % 1000);
			o.serial_ms = cnt[44:0];
			return o;
		endfunction

		function void note_request(req_t r);
			pending.push_back(convert(r));
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				stray++;
				$display("unexpected response %p", a);
				return;
			end
			e = pending.pop_front();
			if (a !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected %p, got %p", $time, e, a);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	conversion_scoreboard board;
	bit calm;          // no idling on either side during this stretch
	int quiet_cycles = 0;

	calendar_millisecond_converter #(.YEAR_SPAN(SPAN)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drives one request transaction; note it in the scoreboard on accept.
	// Valid stays high into the next call; an idle cycle drops it.
	task automatic send_request(req_t r);
		while (!calm && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		board.note_request(r);
		@(negedge clk);
	endtask

	task automatic send_date(logic [1:0] act, int y, int mo, int d, int h, int mi,
			int s, int ms, longint unsigned amt);
		req_t r;
		r.action = act;
		r.year = 12'(y);
		r.month = 4'(mo);
		r.day = 5'(d);
		r.hour = 5'(h);
		r.minute = 6'(mi);
		r.second = 6'(s);
		r.millisecond = 10'(ms);
		r.amount_ms = 45'(amt);
		send_request(r);
	endtask

	// Mostly legal dates inside the span, with some fully random noise.
	function automatic req_t random_request();
		req_t r;
		r = '0;
		r.action = 2'($urandom_range(3));
		if ($urandom_range(99) < 15) begin
			r.year = 12'($urandom);
			r.month = 4'($urandom);
			r.day = 5'($urandom);
			r.hour = 5'($urandom);
			r.minute = 6'($urandom);
			r.second = 6'($urandom);
			r.millisecond = 10'($urandom);
			r.amount_ms = {13'($urandom), 32'($urandom)};
		end else begin
			// small years keep the year walk short most of the time
			r.year = 12'(($urandom_range(9) == 0) ? $urandom_range(1600, 1600 + SPAN - 1)
				: $urandom_range(1600, 1700));
			r.month = 4'($urandom_range(1, 12));
			r.day = 5'($urandom_range(1, 28));
			r.hour = 5'($urandom_range(23));
			r.minute = 6'($urandom_range(59));
			r.second = 6'($urandom_range(59));
			r.millisecond = 10'($urandom_range(999));
			case ($urandom_range(3))
				0: r.amount_ms = 45'($urandom);
				1: r.amount_ms = {13'($urandom_range(0, 40)), 32'($urandom)};
				2: r.amount_ms = 45'($urandom_range(0, 100000));
				default: r.amount_ms = {13'($urandom), 32'($urandom)};
			endcase
		end
		return r;
	endfunction

	// Response side: random stall, compare on accept.
	always @(negedge clk) begin
		if (!arst_n) rsp_stall <= 1'b0;
		else rsp_stall <= !calm && ($urandom_range(99) < 6);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) board.check_response(rsp);
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		longint unsigned top;
		board = new();
		calm = 1'b0;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		top = board.serial_cap();

		// Directed: boundaries, every action, each error path.
		send_date(ACT_TO_COUNT, 1600, 1, 1, 0, 0, 0, 0, 0);
		send_date(ACT_TO_COUNT, 1600 + SPAN - 1, 12, 31, 23, 59, 59, 999, 0);
		send_date(ACT_TO_COUNT, 1600, 1, 0, 0, 0, 0, 0, 0);          // day zero
		send_date(ACT_TO_COUNT, 1600, 0, 5, 0, 0, 0, 0, 0);          // month zero
		send_date(ACT_TO_COUNT, 1600, 13, 0, 0, 0, 0, 0, 0);         // day zero first
		send_date(ACT_TO_COUNT, 1600, 15, 31, 0, 0, 0, 0, 0);        // bad month
		send_date(ACT_TO_COUNT, 1700, 2, 29, 0, 0, 0, 0, 0);         // common century
		send_date(ACT_TO_COUNT, 2000, 2, 29, 0, 0, 0, 0, 0);         // leap century
		send_date(ACT_TO_COUNT, 1604, 4, 31, 0, 0, 0, 0, 0);         // short month
		send_date(ACT_TO_COUNT, 1599, 1, 1, 0, 0, 0, 0, 0);          // year low
		send_date(ACT_TO_COUNT, 1600 + SPAN, 1, 1, 0, 0, 0, 0, 0);   // year high
		send_date(ACT_TO_COUNT, 4095, 2, 30, 0, 0, 0, 0, 0);         // day before year
		send_date(ACT_TO_COUNT, 1600, 1, 1, 31, 63, 63, 1023, 0);    // time carry
		send_date(ACT_TO_COUNT, 1600 + SPAN - 1, 12, 31, 31, 63, 63, 1023, 0);
		send_date(ACT_TO_DATE, 0, 0, 0, 0, 0, 0, 0, 0);
		send_date(ACT_TO_DATE, 0, 0, 0, 0, 0, 0, 0, top - 1);
		send_date(ACT_TO_DATE, 0, 0, 0, 0, 0, 0, 0, top);
		send_date(ACT_TO_DATE, 4095, 15, 31, 31, 63, 63, 1023, 64'h1FFF_FFFF_FFFF);
		send_date(ACT_ADD, 1600, 1, 1, 0, 0, 0, 0, top - 1);
		send_date(ACT_ADD, 1600, 1, 1, 0, 0, 0, 1, top - 1);         // overflow
		send_date(ACT_ADD, 1600, 3, 1, 0, 0, 0, 0, DAY_MS);
		send_date(ACT_SUB, 1600, 1, 1, 0, 0, 0, 5, 5);
		send_date(ACT_SUB, 1600, 1, 1, 0, 0, 0, 5, 6);               // underflow
		send_date(ACT_SUB, 1601, 3, 1, 0, 0, 0, 0, DAY_MS);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 200 && n < 280);
			send_request(random_request());
		end
		req_valid <= 1'b0;
		calm = 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0 && board.stray == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/cmc_pkg.sv
hw/rtl/cmc_ctrl.sv
hw/rtl/cmc_datapath.sv
hw/rtl/calendar_millisecond_converter.sv
hw/rtl/cmc_checker.sv
sim/calendar_millisecond_converter_test.sv
